>>> src/assert_macros.svh
// assertion macros used by the top level rtl file
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge out of reset
`define CHK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every clock edge, reset included
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/fpk_pkg.sv
// types and constants for the finger planar kinematics unit
// used by fpk_trig, fpk_accum and the top level; no dependencies
package fpk_pkg;

  localparam int NUM_FINGERS = 5;
  localparam int FINGER_W    = 3;
  localparam int ANGLE_W     = 16;
  localparam int ANG_W       = 18;
  localparam int LEN_W       = 16;
  localparam int REG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_W       = 20;
  localparam int ACC_W       = 50;
  localparam int PROD_W      = 48;
  localparam int T_W         = 30;
  localparam int TERM_W      = 31;
  localparam int SC_W        = 32;
  localparam int FRAC_Q      = 30;

  localparam logic [ANG_W-1:0] ANG_BIAS     = 18'd138240;
  localparam logic [15:0]      FULL_TURN    = 16'd46080;
  localparam logic [15:0]      QUARTER_TURN = 16'd11520;
  localparam logic [13:0]      EIGHTH_TURN  = 14'd5760;

  // pi/2 in q30 split as 11520 * HALF_PI_WHOLE + HALF_PI_FRAC
  localparam logic [17:0] HALF_PI_WHOLE = 18'd146408;
  localparam logic [13:0] HALF_PI_FRAC  = 14'd9553;
  localparam logic [18:0] RCP_45        = 19'd372828;
  localparam int          RCP_45_SH     = 24;

  localparam int SERIES_STEPS = 6;
  localparam int SIN_STEPS    = 5;
  localparam int SIN_DIV [SERIES_STEPS] = '{6, 20, 42, 72, 110, 1};
  localparam int COS_DIV [SERIES_STEPS] = '{2, 12, 30, 56, 90, 132};

  // register delays through one trig lane
  localparam int LANE_LAT = 7 + 2 * SERIES_STEPS;

  localparam logic [REG_W-1:0] LEN_RESET [NUM_FINGERS] = '{
    64'd216177180244182272, 64'd180147283730369024, 64'd180147833486182912,
    64'd180147283713591552, 64'd144117936930425088
  };

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  typedef struct packed {
    logic [FINGER_W-1:0]      finger;
    logic signed [ANGLE_W-1:0] angle_meta;
    logic signed [ANGLE_W-1:0] angle_prox;
    logic signed [ANGLE_W-1:0] angle_dist;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] meta_x;
    logic signed [OUT_W-1:0] meta_y;
    logic signed [OUT_W-1:0] prox_x;
    logic signed [OUT_W-1:0] prox_y;
    logic signed [OUT_W-1:0] tip_x;
    logic signed [OUT_W-1:0] tip_y;
  } out_item_t;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

>>> src/finger_planar_forward_kinematics_unit.sv
// top level of the finger planar kinematics unit: length registers, entry stage,
// three trig lanes, length delay line, accumulator and output register
// depends on fpk_pkg, fpk_trig, fpk_accum, assert_macros.svh
//
//   channel  direction  ports                                   payload
//   in       input      in_valid, in_stall, in_item             fpk_pkg::in_item_t
//   out      output     out_valid, out_stall, out_item          fpk_pkg::out_item_t
//   cfg      input      cfg_we, cfg_index, cfg_data             64-bit length register
//
// one item per cycle while in_stall is low
// most registers lie in the trig lanes: 12 taylor series stages plus angle scaling
// rst_n clears the length registers to their defaults and all valid bits
// a stalled result holds the pipeline only when its last stage holds an item
`include "assert_macros.svh"

module finger_planar_forward_kinematics_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fpk_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fpk_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [fpk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fpk_pkg::REG_W-1:0]           cfg_data
);

  localparam int NF  = fpk_pkg::NUM_FINGERS;
  localparam int LAT = fpk_pkg::LANE_LAT;

  // length registers
  logic [fpk_pkg::REG_W-1:0] len_r [NF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NF; i++) begin
        len_r[i] <= fpk_pkg::LEN_RESET[i];
      end
    end else if (cfg_we && (cfg_index < fpk_pkg::CFG_IDX_W'(NF))) begin
      len_r[cfg_index] <= cfg_data;
    end
  end

  // pipeline enable
  logic               en;
  logic               out_load;
  logic               tail_vld;
  fpk_pkg::out_item_t tail;
  logic               out_valid_r;
  fpk_pkg::out_item_t out_item_r;

  assign out_load = !out_valid_r || !out_stall;
  assign en       = out_load || !tail_vld;
  assign in_stall = !en;

  // entry stage
  logic                             s0_vld_r;
  logic [fpk_pkg::FINGER_W-1:0]     s0_finger_r;
  logic signed [fpk_pkg::ANG_W-1:0] a1_r, a2_r, a3_r;
  logic [fpk_pkg::REG_W-1:0]        s0_len_r;
  logic signed [fpk_pkg::ANG_W-1:0] a1_nxt, a2_nxt, a3_nxt;
  logic [fpk_pkg::REG_W-1:0]        len_nxt;

  always_comb begin
    a1_nxt = fpk_pkg::ANG_W'(in_item.angle_meta);
    a2_nxt = a1_nxt + fpk_pkg::ANG_W'(in_item.angle_prox);
    a3_nxt = a2_nxt + fpk_pkg::ANG_W'(in_item.angle_dist);
    len_nxt = '0;
    for (int i = 0; i < NF; i++) begin
      if (in_item.finger == fpk_pkg::FINGER_W'(i)) begin
        len_nxt = len_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_finger_r <= in_item.finger;
      a1_r        <= a1_nxt;
      a2_r        <= a2_nxt;
      a3_r        <= a3_nxt;
      s0_len_r    <= len_nxt;
    end
  end

  // trig lanes
  logic signed [fpk_pkg::SC_W-1:0] s1, c1, s2, c2, s3, c3;

  fpk_trig u_trig_meta (.clk(clk), .en(en), .ang(a1_r), .sin_o(s1), .cos_o(c1));
  fpk_trig u_trig_prox (.clk(clk), .en(en), .ang(a2_r), .sin_o(s2), .cos_o(c2));
  fpk_trig u_trig_dist (.clk(clk), .en(en), .ang(a3_r), .sin_o(s3), .cos_o(c3));

  // lengths and valid bits alongside the lanes
  logic                      vld_d_r [1:LAT];
  logic [fpk_pkg::REG_W-1:0] len_d_r [1:LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= LAT; i++) begin
        vld_d_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_d_r[1] <= s0_vld_r;
      for (int i = 2; i <= LAT; i++) begin
        vld_d_r[i] <= vld_d_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_d_r[1] <= s0_len_r;
      for (int i = 2; i <= LAT; i++) begin
        len_d_r[i] <= len_d_r[i-1];
      end
    end
  end

  fpk_pkg::pipe_ctl_t acc_ctl;

  assign acc_ctl.en  = en;
  assign acc_ctl.vld = vld_d_r[LAT];

  fpk_accum u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (acc_ctl),
    .lens     (len_d_r[LAT]),
    .s1       (s1),
    .c1       (c1),
    .s2       (s2),
    .c2       (c2),
    .s3       (s3),
    .c3       (c3),
    .tail_vld (tail_vld),
    .tail     (tail)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= tail_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= tail;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `CHK_CLK(a_tail_held, (tail_vld && out_valid_r && out_stall) |=> (tail_vld && $stable(tail)), "finished item lost under stall")
  `CHK_CLK(a_zero_len, (s0_vld_r && (s0_finger_r >= fpk_pkg::FINGER_W'(NF))) |-> (s0_len_r == '0), "unknown finger has nonzero lengths")
  `CHK_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid_r && !s0_vld_r), "valid bits not cleared by reset")

endmodule

>>> src/fpk_trig.sv
// one sine/cosine lane: angle wrap, quadrant fold, radian scaling, taylor series
// depends on fpk_pkg; advances on en
module fpk_trig (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [fpk_pkg::ANG_W-1:0]  ang,
  output logic signed [fpk_pkg::SC_W-1:0]   sin_o,
  output logic signed [fpk_pkg::SC_W-1:0]   cos_o
);

  localparam int SN = fpk_pkg::SERIES_STEPS;

  // wrap to one turn
  logic [fpk_pkg::ANG_W-1:0] v;
  logic [15:0]               u_nxt;
  logic [15:0]               u_r;

  always_comb begin
    v = $unsigned(ang) + fpk_pkg::ANG_BIAS;
    if (v >= 18'(5 * 46080)) begin
      u_nxt = 16'(v - 18'(5 * 46080));
    end else if (v >= 18'(4 * 46080)) begin
      u_nxt = 16'(v - 18'(4 * 46080));
    end else if (v >= 18'(3 * 46080)) begin
      u_nxt = 16'(v - 18'(3 * 46080));
    end else if (v >= 18'(2 * 46080)) begin
      u_nxt = 16'(v - 18'(2 * 46080));
    end else if (v >= 18'(fpk_pkg::FULL_TURN)) begin
      u_nxt = 16'(v - 18'(fpk_pkg::FULL_TURN));
    end else begin
      u_nxt = 16'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= u_nxt;
    end
  end

  // quadrant and fold
  fpk_pkg::quad_t q_nxt, q2_r, q3_r, q4_r, q5_r, q6_r;
  logic [13:0]    rq;
  logic [12:0]    r_nxt, r2_r;
  logic           sw_nxt, sw2_r, sw3_r, sw4_r, sw5_r, sw6_r;

  always_comb begin
    if (u_r >= 16'(3 * 11520)) begin
      q_nxt = fpk_pkg::QUAD_IV;
      rq    = 14'(u_r - 16'(3 * 11520));
    end else if (u_r >= 16'(2 * 11520)) begin
      q_nxt = fpk_pkg::QUAD_III;
      rq    = 14'(u_r - 16'(2 * 11520));
    end else if (u_r >= fpk_pkg::QUARTER_TURN) begin
      q_nxt = fpk_pkg::QUAD_II;
      rq    = 14'(u_r - fpk_pkg::QUARTER_TURN);
    end else begin
      q_nxt = fpk_pkg::QUAD_I;
      rq    = 14'(u_r);
    end
    if (rq > fpk_pkg::EIGHTH_TURN) begin
      r_nxt  = 13'(14'(fpk_pkg::QUARTER_TURN) - rq);
      sw_nxt = 1'b1;
    end else begin
      r_nxt  = 13'(rq);
      sw_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r  <= r_nxt;
      q2_r  <= q_nxt;
      sw2_r <= sw_nxt;
    end
  end

  // radian scaling, whole part and remainder product
  logic [30:0] a3_r;
  logic [25:0] x3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a3_r  <= 31'(r2_r) * 31'(fpk_pkg::HALF_PI_WHOLE);
      x3_r  <= 26'(26'(r2_r) * 26'(fpk_pkg::HALF_PI_FRAC) + 26'(fpk_pkg::EIGHTH_TURN));
      q3_r  <= q2_r;
      sw3_r <= sw2_r;
    end
  end

  // divide remainder by 11520 as a shift by 8 and a reciprocal of 45
  logic [36:0] quot_p;
  logic [30:0] a4_r;
  logic [12:0] quot4_r;

  assign quot_p = 37'(x3_r[25:8]) * 37'(fpk_pkg::RCP_45);

  always_ff @(posedge clk) begin
    if (en) begin
      a4_r    <= a3_r;
      quot4_r <= quot_p[fpk_pkg::RCP_45_SH +: 13];
      q4_r    <= q3_r;
      sw4_r   <= sw3_r;
    end
  end

  logic [fpk_pkg::T_W-1:0] t5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t5_r  <= fpk_pkg::T_W'(a4_r + 31'(quot4_r));
      q5_r  <= q4_r;
      sw5_r <= sw4_r;
    end
  end

  // t squared, rounded to q30
  logic [59:0] tt;
  logic [60:0] tt_rnd;

  assign tt     = 60'(t5_r) * 60'(t5_r);
  assign tt_rnd = 61'(tt) + 61'(1 << 29);

  logic [fpk_pkg::TERM_W-1:0]      st_r [0:SN];
  logic [fpk_pkg::TERM_W-1:0]      ct_r [0:SN];
  logic signed [fpk_pkg::SC_W-1:0] ss_r [0:SN];
  logic signed [fpk_pkg::SC_W-1:0] cs_r [0:SN];
  logic [fpk_pkg::T_W-1:0]         t2b_r [0:SN];
  fpk_pkg::quad_t                  qb_r [0:SN];
  logic                            swb_r [0:SN];

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= fpk_pkg::TERM_W'(t5_r);
      ss_r[0]  <= fpk_pkg::SC_W'(t5_r);
      ct_r[0]  <= fpk_pkg::TERM_W'(1 << 30);
      cs_r[0]  <= fpk_pkg::SC_W'(1 << 30);
      t2b_r[0] <= tt_rnd[fpk_pkg::FRAC_Q +: fpk_pkg::T_W];
      qb_r[0]  <= q5_r;
      swb_r[0] <= sw5_r;
    end
  end

  // series steps, two stages each
  logic [fpk_pkg::T_W-1:0]         ps_r  [0:SN-1];
  logic [fpk_pkg::T_W-1:0]         pc_r  [0:SN-1];
  logic signed [fpk_pkg::SC_W-1:0] ssa_r [0:SN-1];
  logic signed [fpk_pkg::SC_W-1:0] csa_r [0:SN-1];
  logic [fpk_pkg::T_W-1:0]         t2a_r [0:SN-1];
  fpk_pkg::quad_t                  qa_r  [0:SN-1];
  logic                            swa_r [0:SN-1];

  for (genvar g = 0; g < SN; g++) begin : g_step
    localparam int DC = fpk_pkg::COS_DIV[g];
    localparam int KC = 30 + $clog2(DC);
    localparam logic [63:0] MC = ((64'd1 << KC) + 64'(DC) - 64'd1) / 64'(DC);

    logic [60:0] ps_full, pc_full;
    logic [63:0] cq;

    assign ps_full = 61'(st_r[g]) * 61'(t2b_r[g]);
    assign pc_full = 61'(ct_r[g]) * 61'(t2b_r[g]);
    assign cq      = 64'(pc_r[g]) * MC;

    always_ff @(posedge clk) begin
      if (en) begin
        ps_r[g]  <= ps_full[fpk_pkg::FRAC_Q +: fpk_pkg::T_W];
        pc_r[g]  <= pc_full[fpk_pkg::FRAC_Q +: fpk_pkg::T_W];
        ssa_r[g] <= ss_r[g];
        csa_r[g] <= cs_r[g];
        t2a_r[g] <= t2b_r[g];
        qa_r[g]  <= qb_r[g];
        swa_r[g] <= swb_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ct_r[g+1]  <= fpk_pkg::TERM_W'(cq >> KC);
        cs_r[g+1]  <= (g % 2 == 0) ?
                      csa_r[g] - fpk_pkg::SC_W'(cq >> KC) :
                      csa_r[g] + fpk_pkg::SC_W'(cq >> KC);
        t2b_r[g+1] <= t2a_r[g];
        qb_r[g+1]  <= qa_r[g];
        swb_r[g+1] <= swa_r[g];
      end
    end

    if (g < fpk_pkg::SIN_STEPS) begin : g_sin
      localparam int DS = fpk_pkg::SIN_DIV[g];
      localparam int KS = 30 + $clog2(DS);
      localparam logic [63:0] MS = ((64'd1 << KS) + 64'(DS) - 64'd1) / 64'(DS);

      logic [63:0] sq;

      assign sq = 64'(ps_r[g]) * MS;

      always_ff @(posedge clk) begin
        if (en) begin
          st_r[g+1] <= fpk_pkg::TERM_W'(sq >> KS);
          ss_r[g+1] <= (g % 2 == 0) ?
                       ssa_r[g] - fpk_pkg::SC_W'(sq >> KS) :
                       ssa_r[g] + fpk_pkg::SC_W'(sq >> KS);
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          st_r[g+1] <= fpk_pkg::TERM_W'(ps_r[g]);
          ss_r[g+1] <= ssa_r[g];
        end
      end
    end
  end

  // unfold and place in quadrant
  logic signed [fpk_pkg::SC_W-1:0] s0, c0, s_nxt, c_nxt;

  always_comb begin
    s0 = swb_r[SN] ? cs_r[SN] : ss_r[SN];
    c0 = swb_r[SN] ? ss_r[SN] : cs_r[SN];
    case (qb_r[SN])
      fpk_pkg::QUAD_I: begin
        s_nxt = s0;
        c_nxt = c0;
      end
      fpk_pkg::QUAD_II: begin
        s_nxt = c0;
        c_nxt = -s0;
      end
      fpk_pkg::QUAD_III: begin
        s_nxt = -s0;
        c_nxt = -c0;
      end
      fpk_pkg::QUAD_IV: begin
        s_nxt = -c0;
        c_nxt = s0;
      end
      default: begin
        s_nxt = s0;
        c_nxt = c0;
      end
    endcase
  end

  logic signed [fpk_pkg::SC_W-1:0] sin_r, cos_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= s_nxt;
      cos_r <= c_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

>>> src/fpk_accum.sv
// segment vector products, running sums and rounding to q11.8
// depends on fpk_pkg; four register stages, advances on ctl.en
module fpk_accum (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fpk_pkg::pipe_ctl_t                ctl,
  input  logic [fpk_pkg::REG_W-1:0]         lens,
  input  logic signed [fpk_pkg::SC_W-1:0]   s1,
  input  logic signed [fpk_pkg::SC_W-1:0]   c1,
  input  logic signed [fpk_pkg::SC_W-1:0]   s2,
  input  logic signed [fpk_pkg::SC_W-1:0]   c2,
  input  logic signed [fpk_pkg::SC_W-1:0]   s3,
  input  logic signed [fpk_pkg::SC_W-1:0]   c3,
  output logic                              tail_vld,
  output fpk_pkg::out_item_t                tail
);

  localparam int LW = fpk_pkg::LEN_W;
  localparam int PW = fpk_pkg::PROD_W;
  localparam int AW = fpk_pkg::ACC_W;

  logic [3:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.en) begin
      vld_r <= {vld_r[2:0], ctl.vld};
    end
  end

  assign tail_vld = vld_r[3];

  // products
  logic signed [LW:0]   l1s, l2s, l3s;
  logic signed [PW-1:0] p1x_r, p1y_r, p2x_r, p2y_r, p3x_r, p3y_r;
  logic signed [AW-1:0] base_r;

  assign l1s = $signed({1'b0, lens[2*LW-1:LW]});
  assign l2s = $signed({1'b0, lens[3*LW-1:2*LW]});
  assign l3s = $signed({1'b0, lens[4*LW-1:3*LW]});

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p1x_r  <= PW'(l1s) * PW'(c1);
      p1y_r  <= PW'(l1s) * PW'(s1);
      p2x_r  <= PW'(l2s) * PW'(c2);
      p2y_r  <= PW'(l2s) * PW'(s2);
      p3x_r  <= PW'(l3s) * PW'(c3);
      p3y_r  <= PW'(l3s) * PW'(s3);
      base_r <= $signed(AW'({lens[LW-1:0], {fpk_pkg::FRAC_Q{1'b0}}}));
    end
  end

  // first point and partial sums
  logic signed [AW-1:0] x1_r, y1_r, x23_r, y23_r, x2p_r, y2p_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      x1_r  <= base_r + AW'(p1x_r);
      y1_r  <= AW'(p1y_r);
      x23_r <= AW'(p2x_r) + AW'(p3x_r);
      y23_r <= AW'(p2y_r) + AW'(p3y_r);
      x2p_r <= AW'(p2x_r);
      y2p_r <= AW'(p2y_r);
    end
  end

  logic signed [AW-1:0] xm_r, ym_r, xp_r, yp_r, xt_r, yt_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      xm_r <= x1_r;
      ym_r <= y1_r;
      xp_r <= x1_r + x2p_r;
      yp_r <= y1_r + y2p_r;
      xt_r <= x1_r + x23_r;
      yt_r <= y1_r + y23_r;
    end
  end

  // round to nearest, ties up
  function automatic logic signed [fpk_pkg::OUT_W-1:0] rnd(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] s;
    s = a + AW'(1 << 29);
    return s[fpk_pkg::FRAC_Q +: fpk_pkg::OUT_W];
  endfunction

  fpk_pkg::out_item_t tail_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      tail_r.meta_x <= rnd(xm_r);
      tail_r.meta_y <= rnd(ym_r);
      tail_r.prox_x <= rnd(xp_r);
      tail_r.prox_y <= rnd(yp_r);
      tail_r.tip_x  <= rnd(xt_r);
      tail_r.tip_y  <= rnd(yt_r);
    end
  end

  assign tail = tail_r;

endmodule
